// ===== rtl/core/clp_pkg.sv =====
// Package for the calibrated line position unit.
// Holds payload structs, request and mode codes, sequencer states and constants.
// No dependencies.
package clp_pkg;

  localparam int unsigned NumSens    = 5;
  localparam int unsigned CalSamples = 10;
  localparam int unsigned CntW       = 6;
  localparam int unsigned ValW       = 15;
  localparam int unsigned LvlW       = 10;
  localparam int unsigned PosW       = 12;

  localparam logic [ValW-1:0] TimeoutReset = 15'd4000;
  localparam logic [LvlW-1:0] LevelFull    = 10'd1000;
  localparam logic [LvlW-1:0] SeenThresh   = 10'd200;
  localparam logic [LvlW-1:0] NoiseThresh  = 10'd50;
  localparam logic [PosW-1:0] PosMid       = 12'd2000;
  localparam logic [PosW-1:0] PosFar       = 12'd4000;

  typedef enum logic [1:0] {
    REQ_CAL   = 2'd0,
    REQ_BLACK = 2'd1,
    REQ_WHITE = 2'd2,
    REQ_RESET = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    MODE_ON     = 2'd0,
    MODE_OFF    = 2'd1,
    MODE_MANUAL = 2'd2,
    MODE_SPARE  = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CAL,
    ST_SCALE,
    ST_DIV,
    ST_POS,
    ST_PDIV,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [1:0]  emitter_mode;
    logic [15:0] raw0;
    logic [15:0] raw1;
    logic [15:0] raw2;
    logic [15:0] raw3;
    logic [15:0] raw4;
  } in_item_t;

  typedef struct packed {
    logic [PosW-1:0] position;
    logic [LvlW-1:0] level0;
    logic [LvlW-1:0] level1;
    logic [LvlW-1:0] level2;
    logic [LvlW-1:0] level3;
    logic [LvlW-1:0] level4;
    logic            line_seen;
  } out_item_t;

endpackage

// ===== rtl/core/calibrated_line_position_unit.sv =====
// Calibrated line position unit: top level with sequencer and shared divider.
// Depends on clp_pkg.
// Calibrate and reset items pass through ST_CAL to ST_OUT. Reads scale each sensor,
// with a 25-step restoring division for a level that is neither zero nor full, then
// a 25-step division for the position when the line is seen, then ST_OUT.
// One item at a time; the next is accepted once the result register is taken.
// Reset restores the timeout to 4000, sets the low bounds to 4000 and the high bounds to 0, and clears flags and burst.
module calibrated_line_position_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [14:0]       cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  clp_pkg::in_item_t in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output clp_pkg::out_item_t out_item_o
);
  import clp_pkg::*;

  localparam int unsigned DivW = 25;

  state_e state_q, state_d;

  logic [ValW-1:0] timeout_q;
  logic [ValW-1:0] lo_on_q [NumSens];
  logic [ValW-1:0] hi_on_q [NumSens];
  logic [ValW-1:0] lo_off_q [NumSens];
  logic [ValW-1:0] hi_off_q [NumSens];
  logic [ValW-1:0] bmin_q [NumSens];
  logic [ValW-1:0] bmax_q [NumSens];
  logic [ValW-1:0] val_q [NumSens];
  logic [LvlW-1:0] lvl_q [NumSens];
  logic            cal_on_q, cal_off_q;
  logic [CntW-1:0] bcnt_q;
  logic [PosW-1:0] last_pos_q;
  logic [1:0]      req_q, mode_q;
  logic [2:0]      idx_q;
  logic [4:0]      step_q;
  logic            out_valid_q;
  out_item_t       out_q;

  // Shared restoring divider registers.
  logic [DivW-1:0] num_q, quo_q;
  logic [DivW-1:0] den_q;
  logic [DivW:0]   rem_q;
  logic [DivW:0]   rem_sh;
  logic            rem_ge;

  // Clamped halves of the incoming raw times.
  logic [15:0]     raw_in [NumSens];
  logic [ValW-1:0] val_in [NumSens];

  always_comb begin
    raw_in[0] = in_item_i.raw0;
    raw_in[1] = in_item_i.raw1;
    raw_in[2] = in_item_i.raw2;
    raw_in[3] = in_item_i.raw3;
    raw_in[4] = in_item_i.raw4;
    for (int i = 0; i < NumSens; i++) begin
      val_in[i] = (raw_in[i][15:1] > timeout_q) ? timeout_q : raw_in[i][15:1];
    end
  end

  logic accept;
  assign in_stall_o  = (state_q != ST_IDLE) || out_valid_q;
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Bounds for the current read sensor.
  logic            use_on, use_off, use_cal;
  logic [ValW-1:0] cur_lo, cur_hi, cur_v;
  logic [2:0]      idx_w;
  logic            skip_zero, skip_full;
  assign idx_w   = (idx_q < 3'(NumSens)) ? idx_q : 3'd0;
  assign use_on  = (mode_q == MODE_ON) && cal_on_q;
  assign use_off = (mode_q == MODE_OFF) && cal_off_q;
  assign use_cal = use_on || use_off;
  assign cur_lo  = use_on ? lo_on_q[idx_w] : lo_off_q[idx_w];
  assign cur_hi  = use_on ? hi_on_q[idx_w] : hi_off_q[idx_w];
  assign cur_v   = val_q[idx_w];
  assign skip_zero = !use_cal || (cur_hi <= cur_lo) || (cur_v <= cur_lo);
  assign skip_full = cur_v >= cur_hi;

  // Weighted sum of the middle levels above the noise floor.
  logic [LvlW-1:0] mid [3];
  logic            seen;
  logic [11:0]     tot;
  logic [DivW-1:0] wsum;
  always_comb begin
    seen = 1'b0;
    tot  = '0;
    wsum = '0;
    for (int i = 0; i < 3; i++) begin
      mid[i] = (req_q == REQ_WHITE) ? LevelFull - lvl_q[i+1] : lvl_q[i+1];
      if (mid[i] > SeenThresh) seen = 1'b1;
      if (mid[i] > NoiseThresh) begin
        tot  = tot + 12'(mid[i]);
        wsum = wsum + DivW'(mid[i]) * DivW'(i + 1);
      end
    end
  end

  // One divider step: shift in the next numerator bit and try a subtract.
  assign rem_sh = {rem_q[DivW-1:0], num_q[DivW-1]};
  assign rem_ge = rem_sh >= {1'b0, den_q};

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (accept) begin
        state_d = (in_item_i.req_type == REQ_CAL || in_item_i.req_type == REQ_RESET)
                  ? ST_CAL : ST_SCALE;
      end
      ST_CAL:   state_d = ST_OUT;
      ST_SCALE: begin
        if (idx_q == 3'(NumSens - 1) && (skip_zero || skip_full)) state_d = ST_POS;
        else if (!(skip_zero || skip_full)) state_d = ST_DIV;
      end
      ST_DIV:   if (step_q == 5'd0) begin
        state_d = (idx_q == 3'(NumSens - 1)) ? ST_POS : ST_SCALE;
      end
      ST_POS:   state_d = (seen && tot != '0) ? ST_PDIV : ST_OUT;
      ST_PDIV:  if (step_q == 5'd0) state_d = ST_OUT;
      ST_OUT:   state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_OUT) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // Calibration state and timeout register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q  <= TimeoutReset;
      cal_on_q   <= 1'b0;
      cal_off_q  <= 1'b0;
      bcnt_q     <= '0;
      last_pos_q <= '0;
      for (int i = 0; i < NumSens; i++) begin
        lo_on_q[i]  <= TimeoutReset;
        lo_off_q[i] <= TimeoutReset;
        hi_on_q[i]  <= '0;
        hi_off_q[i] <= '0;
        bmin_q[i]   <= TimeoutReset;
        bmax_q[i]   <= '0;
      end
    end else begin
      if (cfg_we_i) timeout_q <= (cfg_wdata_i == '0) ? 15'd1 : cfg_wdata_i;
      if (state_q == ST_CAL && req_q == REQ_RESET) begin
        cal_on_q   <= 1'b0;
        cal_off_q  <= 1'b0;
        last_pos_q <= '0;
        bcnt_q     <= '0;
        for (int i = 0; i < NumSens; i++) begin
          lo_on_q[i]  <= timeout_q;
          lo_off_q[i] <= timeout_q;
          hi_on_q[i]  <= '0;
          hi_off_q[i] <= '0;
          bmin_q[i]   <= timeout_q;
          bmax_q[i]   <= '0;
        end
      end else if (state_q == ST_CAL && (mode_q == MODE_ON || mode_q == MODE_OFF)) begin
        if (bcnt_q + 1'b1 >= CntW'(CalSamples)) begin
          // Burst complete: widen the bounds of this emitter mode.
          for (int i = 0; i < NumSens; i++) begin
            logic [ValW-1:0] mn, mx;
            mn = (val_q[i] < bmin_q[i]) ? val_q[i] : bmin_q[i];
            mx = (val_q[i] > bmax_q[i]) ? val_q[i] : bmax_q[i];
            if (mode_q == MODE_ON) begin
              if (mn > hi_on_q[i]) hi_on_q[i] <= mn;
              if (mx < lo_on_q[i]) lo_on_q[i] <= mx;
            end else begin
              if (mn > hi_off_q[i]) hi_off_q[i] <= mn;
              if (mx < lo_off_q[i]) lo_off_q[i] <= mx;
            end
            bmin_q[i] <= timeout_q;
            bmax_q[i] <= '0;
          end
          if (mode_q == MODE_ON) cal_on_q <= 1'b1;
          else cal_off_q <= 1'b1;
          bcnt_q <= '0;
        end else begin
          for (int i = 0; i < NumSens; i++) begin
            if (val_q[i] < bmin_q[i]) bmin_q[i] <= val_q[i];
            if (val_q[i] > bmax_q[i]) bmax_q[i] <= val_q[i];
          end
          bcnt_q <= bcnt_q + 1'b1;
        end
      end
      if (state_q == ST_PDIV && step_q == 5'd0) last_pos_q <= {quo_q[PosW-2:0], rem_ge};
    end
  end

  // Datapath: captured item, levels, divider and result register.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q  <= in_item_i.req_type;
      mode_q <= in_item_i.emitter_mode;
      idx_q  <= '0;
      for (int i = 0; i < NumSens; i++) begin
        val_q[i] <= val_in[i];
        lvl_q[i] <= '0;
      end
    end
    case (state_q)
      ST_SCALE: begin
        if (skip_zero || skip_full) begin
          lvl_q[idx_w] <= skip_zero ? '0 : LevelFull;
          idx_q <= idx_q + 3'd1;
        end else begin
          // (v - lo) * 1000 / (hi - lo), quotient below 1000.
          num_q  <= DivW'(cur_v - cur_lo) * DivW'(LevelFull);
          den_q  <= DivW'(cur_hi - cur_lo);
          rem_q  <= '0;
          quo_q  <= '0;
          step_q <= 5'(DivW - 1);
        end
      end
      ST_DIV, ST_PDIV: begin
        rem_q  <= rem_ge ? rem_sh - {1'b0, den_q} : rem_sh;
        quo_q  <= {quo_q[DivW-2:0], rem_ge};
        num_q  <= {num_q[DivW-2:0], 1'b0};
        step_q <= step_q - 5'd1;
        if (state_q == ST_DIV && step_q == 5'd0) begin
          lvl_q[idx_w] <= LvlW'({quo_q[DivW-2:0], rem_ge});
          idx_q <= idx_q + 3'd1;
        end
      end
      ST_POS: begin
        num_q  <= wsum * DivW'(LevelFull);
        den_q  <= DivW'(tot);
        rem_q  <= '0;
        quo_q  <= '0;
        step_q <= 5'(DivW - 1);
      end
      ST_OUT: begin
        if (req_q == REQ_BLACK || req_q == REQ_WHITE) begin
          if (seen && tot != '0) out_q.position <= last_pos_q;
          else out_q.position <= (last_pos_q < PosMid) ? '0 : PosFar;
          out_q.level0    <= lvl_q[0];
          out_q.level1    <= mid[0];
          out_q.level2    <= mid[1];
          out_q.level3    <= mid[2];
          out_q.level4    <= lvl_q[4];
          out_q.line_seen <= seen;
        end else begin
          out_q <= '0;
        end
      end
      default: ;
    endcase
  end

  // Checks.
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> in_stall_o) else $error("item accepted while busy");
  a_out_after_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT) |=> out_valid_q) else $error("result lost");
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.position <= PosFar)) else $error("position out of range");

endmodule
